/* design/rcrm_pkg.sv */
// ----------------------------------------------------------------------------
// rcrm_pkg
// types, codes and defaults shared by the reachability marker
// ----------------------------------------------------------------------------
package rcrm_pkg;
    localparam int unsigned NodesDef = 16;
    localparam int unsigned CounterBitsDef = 16;
    localparam int unsigned CmdW = 3;
    localparam int unsigned IdW = 4;
    localparam int unsigned CountW = 20;
    localparam int unsigned StatW = 2;
    localparam logic [CountW-1:0] CountMax = '1;

    typedef enum logic [CmdW-1:0] {
        CMD_DECLARE = 3'd0,
        CMD_ADD_REF = 3'd1,
        CMD_QUERY_PAIR = 3'd2,
        CMD_QUERY_TOTAL = 3'd3,
        CMD_MARK_UNUSED = 3'd4,
        CMD_QUERY_USED = 3'd5
    } t_cmd;

    typedef enum logic [StatW-1:0] {
        ST_OK = 2'd0,
        ST_NOT_DECLARED = 2'd1,
        ST_ALREADY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDW, S_INC, S_PAIR, S_TOT_RD, S_TOT_ACC,
        S_MK_INIT, S_MK_RD, S_MK_CHK, S_MK_POP, S_MK_CLR, S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input word
        logic rd_pair;    // read counter at node/row
        logic inc;        // write incremented counter
        logic cap_pair;   // count = counter
        logic tot_start;  // count = 0, scan index = root
        logic tot_rd;     // read counter at scan row
        logic tot_acc;    // accumulate
        logic mk_init;    // pending = declared, sp = 0, row = root, col = 0
        logic mk_rd;      // read counter at walk row/col
        logic mk_chk;     // push if reached, advance col
        logic mk_pop;     // pop stack into walk row
        logic mk_clr;     // clear unreached used flags
        logic declare;    // do declare
        logic query_used;
        logic fail;       // status not declared
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic node_ok;
        logic parent_ok;
        logic is_decl;
        logic col_last;
        logic tot_last;
        logic stack_empty;
        logic init_busy;  // counter memory clearing pass running
        logic [CmdW-1:0] cmd;
    } t_sts;
endpackage

/* design/rcrm_if.sv */
// ----------------------------------------------------------------------------
// rcrm_in_if / rcrm_out_if
// valid/ready channels for command and result words
// ----------------------------------------------------------------------------
interface rcrm_in_if;
    logic valid;
    logic ready;
    logic [2:0] cmd;
    logic [3:0] node_id;
    logic [3:0] parent_id;
    logic parent_is_root;
    modport source (output valid, cmd, node_id, parent_id, parent_is_root, input ready);
    modport sink (input valid, cmd, node_id, parent_id, parent_is_root, output ready);
endinterface

interface rcrm_out_if;
    logic valid;
    logic ready;
    logic [19:0] count;
    logic used;
    logic [1:0] status;
    modport source (output valid, count, used, status, input ready);
    modport sink (input valid, count, used, status, output ready);
endinterface

/* design/reference_count_reachability_marker_top.sv */
// mark unused walks the counter rows of the root and of each reached node
// one command at a time: the next word is taken only after the result word is accepted
// reset: synchronous active low clears tables and stack pointer, then a clearing
// pass zeroes all (NODES+1)*NODES counters of the counter memory with input held off
// ----------------------------------------------------------------------------
// reference_count_reachability_marker_top
// reference counter matrix with depth-first mark of unreachable nodes
// ----------------------------------------------------------------------------
module reference_count_reachability_marker_top #(
    parameter int unsigned NODES = rcrm_pkg::NodesDef,
    parameter int unsigned COUNTER_BITS = rcrm_pkg::CounterBitsDef
) (
    input logic i_clk,
    input logic i_rst_n,
    rcrm_in_if.sink i_in,
    rcrm_out_if.source o_out
);
    import rcrm_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    rcrm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_sts(w_sts), .o_ctl(w_ctl)
    );

    rcrm_dp #(.NODES(NODES), .COUNTER_BITS(COUNTER_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(i_in.cmd), .i_node_id(i_in.node_id),
        .i_parent_id(i_in.parent_id), .i_parent_is_root(i_in.parent_is_root),
        .i_ctl(w_ctl), .o_sts(w_sts),
        .o_count(o_out.count), .o_used(o_out.used), .o_status(o_out.status)
    );
endmodule

/* design/rcrm_ctrl.sv */
// ----------------------------------------------------------------------------
// rcrm_ctrl
// command sequencer for the reachability marker
// ----------------------------------------------------------------------------
module rcrm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rcrm_pkg::t_sts i_sts,
    output rcrm_pkg::t_ctl o_ctl
);
    import rcrm_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_ctl = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !i_sts.init_busy;
                if (i_in_valid && !i_sts.init_busy) begin
                    o_ctl.load = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                case (i_sts.cmd)
                    CMD_DECLARE: begin
                        if (!i_sts.node_ok) o_ctl.fail = 1'b1;
                        else o_ctl.declare = 1'b1;
                        n_state = S_DONE;
                    end
                    CMD_ADD_REF, CMD_QUERY_PAIR: begin
                        if (!i_sts.node_ok || !i_sts.parent_ok) begin
                            o_ctl.fail = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_ctl.rd_pair = 1'b1;
                            n_state = S_RDW;
                        end
                    end
                    CMD_QUERY_TOTAL: begin
                        if (!i_sts.node_ok) begin
                            o_ctl.fail = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_ctl.tot_start = 1'b1;
                            n_state = S_TOT_RD;
                        end
                    end
                    CMD_MARK_UNUSED: begin
                        o_ctl.mk_init = 1'b1;
                        n_state = S_MK_RD;
                    end
                    CMD_QUERY_USED: begin
                        if (!i_sts.node_ok || !i_sts.is_decl) o_ctl.fail = 1'b1;
                        else o_ctl.query_used = 1'b1;
                        n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RDW: n_state = (i_sts.cmd == CMD_ADD_REF) ? S_INC : S_PAIR;
            S_INC: begin
                o_ctl.inc = 1'b1;
                n_state = S_DONE;
            end
            S_PAIR: begin
                o_ctl.cap_pair = 1'b1;
                n_state = S_DONE;
            end
            S_TOT_RD: begin
                o_ctl.tot_rd = 1'b1;
                n_state = S_TOT_ACC;
            end
            S_TOT_ACC: begin
                o_ctl.tot_acc = 1'b1;
                n_state = i_sts.tot_last ? S_DONE : S_TOT_RD;
            end
            S_MK_INIT: n_state = S_MK_RD;
            S_MK_RD: begin
                o_ctl.mk_rd = 1'b1;
                n_state = S_MK_CHK;
            end
            S_MK_CHK: begin
                o_ctl.mk_chk = 1'b1;
                n_state = i_sts.col_last ? S_MK_POP : S_MK_RD;
            end
            S_MK_POP: begin
                if (i_sts.stack_empty) n_state = S_MK_CLR;
                else begin
                    o_ctl.mk_pop = 1'b1;
                    n_state = S_MK_RD;
                end
            end
            S_MK_CLR: begin
                o_ctl.mk_clr = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // one result word per accepted command, never while idle
    a_no_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_out_valid) else $error("result in idle");
    a_load_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> (r_state == S_RD)) else $error("load not followed by dispatch");
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
endmodule

/* design/rcrm_dp.sv */
// ----------------------------------------------------------------------------
// rcrm_dp
// node tables, counter memory, walk stack and result registers
// ----------------------------------------------------------------------------
module rcrm_dp #(
    parameter int unsigned NODES = rcrm_pkg::NodesDef,
    parameter int unsigned COUNTER_BITS = rcrm_pkg::CounterBitsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rcrm_pkg::CmdW-1:0]     i_cmd,
    input  logic [rcrm_pkg::IdW-1:0]      i_node_id,
    input  logic [rcrm_pkg::IdW-1:0]      i_parent_id,
    input  logic                          i_parent_is_root,
    input  rcrm_pkg::t_ctl                i_ctl,
    output rcrm_pkg::t_sts                o_sts,
    output logic [rcrm_pkg::CountW-1:0]   o_count,
    output logic                          o_used,
    output logic [rcrm_pkg::StatW-1:0]    o_status
);
    import rcrm_pkg::*;

    localparam int unsigned NW = $clog2(NODES);
    localparam int unsigned RW = $clog2(NODES + 1);
    localparam int unsigned DEPTH = (NODES + 1) * NODES;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned SPW = $clog2(NODES + 1);
    localparam int unsigned SW = (COUNTER_BITS > CountW) ? COUNTER_BITS : CountW;
    localparam logic [RW-1:0] ROOT = RW'(NODES);
    localparam logic [COUNTER_BITS-1:0] CMAX = '1;

    logic [NODES-1:0] r_decl, r_used, r_pend;
    logic [COUNTER_BITS-1:0] r_mem [DEPTH];
    logic [COUNTER_BITS-1:0] r_rd;
    logic [NW-1:0] r_stack [NODES];
    logic [SPW-1:0] r_sp;
    logic [CmdW-1:0] r_cmd;
    logic [IdW-1:0] r_node, r_parent;
    logic r_root;
    logic [RW-1:0] r_row;
    logic [NW-1:0] r_col;
    logic [AW-1:0] r_addr;
    logic r_init;
    logic [AW-1:0] r_init_addr;
    logic [CountW-1:0] r_count;
    logic r_used_o;
    logic [StatW-1:0] r_status;
    logic [NW-1:0] w_node;
    logic [RW-1:0] w_prow;
    logic [AW-1:0] n_addr;
    logic [COUNTER_BITS-1:0] w_cnt;
    logic [SW:0] w_sum;
    logic w_add;

    assign w_node = NW'(r_node);
    assign w_prow = r_root ? ROOT : RW'(r_parent);
    assign w_cnt = r_rd;

    assign o_sts.node_ok = ({28'd0, r_node} < 32'(NODES));
    assign o_sts.parent_ok = r_root || ({28'd0, r_parent} < 32'(NODES));
    assign o_sts.is_decl = r_decl[w_node];
    assign o_sts.col_last = (r_col == NW'(NODES - 1));
    assign o_sts.tot_last = (r_row == RW'(NODES - 1));
    assign o_sts.stack_empty = (r_sp == '0);
    assign o_sts.init_busy = r_init;
    assign o_sts.cmd = r_cmd;

    // read address mux
    always_comb begin
        n_addr = r_addr;
        if (i_ctl.rd_pair) n_addr = AW'(w_prow * RW'(NODES)) + AW'(w_node);
        else if (i_ctl.tot_rd) n_addr = AW'(r_row * RW'(NODES)) + AW'(w_node);
        else if (i_ctl.mk_rd) n_addr = AW'(r_row * RW'(NODES)) + AW'(r_col);
    end

    // counter memory, zeroed by the clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_pair || i_ctl.tot_rd || i_ctl.mk_rd) begin
            r_rd <= r_mem[n_addr];
            r_addr <= n_addr;
        end
        if (r_init) r_mem[r_init_addr] <= '0;
        else if (i_ctl.inc) r_mem[r_addr] <= (w_cnt == CMAX) ? CMAX : w_cnt + 1'b1;
    end

    // clearing pass, one counter per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 1'b1;
            r_init_addr <= '0;
        end else if (r_init) begin
            r_init_addr <= r_init_addr + 1'b1;
            if (r_init_addr == AW'(DEPTH - 1)) r_init <= 1'b0;
        end
    end

    // saturating total accumulate
    assign w_add = (r_row == ROOT) || (r_decl[NW'(r_row)] && r_used[NW'(r_row)]);
    assign w_sum = (SW+1)'(r_count) + (SW+1)'(w_add ? w_cnt : '0);

    // input capture, tables, walk and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= '0;
            r_used <= '0;
            r_pend <= '0;
            r_sp <= '0;
        end else begin
            if (i_ctl.load) begin
                r_cmd <= i_cmd;
                r_node <= i_node_id;
                r_parent <= i_parent_id;
                r_root <= i_parent_is_root;
                r_count <= '0;
                r_used_o <= 1'b0;
                r_status <= ST_OK;
            end
            if (i_ctl.fail) r_status <= ST_NOT_DECLARED;
            if (i_ctl.declare) begin
                if (r_decl[w_node]) r_status <= ST_ALREADY;
                else begin
                    r_decl[w_node] <= 1'b1;
                    r_used[w_node] <= 1'b1;
                end
            end
            if (i_ctl.query_used) r_used_o <= r_used[w_node];
            if (i_ctl.cap_pair)
                r_count <= (SW'(w_cnt) > SW'(CountMax)) ? CountMax : CountW'(w_cnt);
            if (i_ctl.tot_start) begin
                r_row <= ROOT;
                r_count <= '0;
            end
            if (i_ctl.tot_acc) begin
                r_count <= (w_sum > (SW+1)'(CountMax)) ? CountMax : CountW'(w_sum);
                r_row <= (r_row == ROOT) ? '0 : r_row + 1'b1;
            end
            if (i_ctl.mk_init) begin
                r_pend <= r_decl;
                r_sp <= '0;
                r_row <= ROOT;
                r_col <= '0;
            end
            if (i_ctl.mk_chk) begin
                if (w_cnt != '0 && r_pend[r_col]) begin
                    r_stack[r_sp[NW-1:0]] <= r_col;
                    r_sp <= r_sp + 1'b1;
                    r_pend[r_col] <= 1'b0;
                end
                r_col <= o_sts.col_last ? '0 : r_col + 1'b1;
            end
            if (i_ctl.mk_pop) begin
                r_sp <= r_sp - 1'b1;
                r_row <= RW'(r_stack[NW'(r_sp - 1'b1)]);
            end
            if (i_ctl.mk_clr) r_used <= r_used & ~(r_decl & r_pend);
        end
    end

    assign o_count = r_count;
    assign o_used = r_used_o;
    assign o_status = r_status;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(NODES)) else $error("stack overrun");
    a_pend_decl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & ~r_decl) == '0) else $error("pending node not declared");
    a_used_decl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used & ~r_decl) == '0) else $error("used flag on undeclared node");
endmodule

/* tb/tb_reference_count_reachability_marker_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reference_count_reachability_marker_top
// drives command words through the reachability marker and checks each
// result word against a behavioral model of the node tables and counters
// ----------------------------------------------------------------------------
module tb_reference_count_reachability_marker_top;
    import rcrm_pkg::*;

    localparam int N = 16;
    localparam int CB = 16;
    localparam int ROOT = N;
    localparam int CNT_LIMIT = (1 << CB) - 1;
    localparam int RANDOM_WORDS = 1950;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic [19:0] count;
        logic used;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] node;
        logic [3:0] parent;
        logic root;
        logic chk;      // expected value typed in below
        t_result res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    rcrm_in_if in_ch();
    rcrm_out_if out_ch();

    reference_count_reachability_marker_top DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch.sink),
        .o_out(out_ch.source)
    );

    // model state
    bit node_declared[N];
    bit node_used[N];
    int unsigned ref_cnt[N+1][N];

    t_result expected_results[$];
    int fail_cnt;
    int result_cnt;
    int word_cnt;
    int cycle_cnt = 0;
    int long_stall;
    bit stim_done;

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results pending", $time, expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // depth-first walk from root, clears used of unreached declared nodes
    function automatic void mark_unreached();
        bit pend[N];
        int stk[$];
        int r;
        for (int i = 0; i < N; i++) pend[i] = node_declared[i];
        stk.push_back(ROOT);
        while (stk.size() > 0) begin
            r = stk.pop_back();
            for (int c = 0; c < N; c++) begin
                if (ref_cnt[r][c] != 0 && pend[c]) begin
                    pend[c] = 0;
                    stk.push_back(c);
                end
            end
        end
        for (int i = 0; i < N; i++)
            if (node_declared[i] && pend[i]) node_used[i] = 0;
    endfunction

    function automatic t_result predict_word(logic [2:0] cmd, int nd, int pr, bit root);
        t_result res;
        int row;
        longint sum;
        res = '0;
        row = root ? ROOT : pr;
        case (cmd)
            CMD_DECLARE: begin
                if (node_declared[nd]) res.status = ST_ALREADY;
                else begin
                    node_declared[nd] = 1;
                    node_used[nd] = 1;
                end
            end
            CMD_ADD_REF: if (ref_cnt[row][nd] < CNT_LIMIT) ref_cnt[row][nd]++;
            CMD_QUERY_PAIR: res.count = 20'(ref_cnt[row][nd]);
            CMD_QUERY_TOTAL: begin
                sum = ref_cnt[ROOT][nd];
                for (int p = 0; p < N; p++)
                    if (node_declared[p] && node_used[p]) sum += ref_cnt[p][nd];
                res.count = (sum > CountMax) ? CountMax : sum[19:0];
            end
            CMD_MARK_UNUSED: mark_unreached();
            CMD_QUERY_USED: begin
                if (!node_declared[nd]) res.status = ST_NOT_DECLARED;
                else res.used = node_used[nd];
            end
            default: ;
        endcase
        return res;
    endfunction

    // send one word, waiting for acceptance
    task automatic send_word(logic [2:0] cmd, logic [3:0] nd, logic [3:0] pr, logic root,
                             bit chk, t_result typed);
        t_result res;
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.node_id <= nd;
        in_ch.parent_id <= pr;
        in_ch.parent_is_root <= root;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        res = predict_word(cmd, nd, pr, root);
        if (chk && res != typed) begin
            $display("%0t table row expected %h actual %h", $time, typed, res);
            fail_cnt++;
        end
        expected_results.push_back(res);
        word_cnt++;
    endtask

    task automatic idle_cycles(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
    endtask

    // directed table
    t_row dir_rows[] = '{
        '{CMD_QUERY_USED, 4'd0, 4'd0, 1'b0, 1'b1, '{20'd0, 1'b0, ST_NOT_DECLARED}},
        '{CMD_QUERY_TOTAL, 4'd15, 4'd0, 1'b1, 1'b1, '{20'd0, 1'b0, ST_OK}},
        '{CMD_DECLARE, 4'd0, 4'd0, 1'b0, 1'b1, '{20'd0, 1'b0, ST_OK}},
        '{CMD_DECLARE, 4'd0, 4'd0, 1'b0, 1'b1, '{20'd0, 1'b0, ST_ALREADY}},
        '{CMD_DECLARE, 4'd15, 4'd0, 1'b0, 1'b1, '{20'd0, 1'b0, ST_OK}},
        '{CMD_DECLARE, 4'd5, 4'd0, 1'b0, 1'b0, '0},
        '{CMD_QUERY_USED, 4'd15, 4'd0, 1'b0, 1'b1, '{20'd0, 1'b1, ST_OK}},
        '{CMD_ADD_REF, 4'd0, 4'd9, 1'b1, 1'b1, '{20'd0, 1'b0, ST_OK}},
        '{CMD_ADD_REF, 4'd15, 4'd0, 1'b0, 1'b0, '0},
        '{CMD_ADD_REF, 4'd7, 4'd15, 1'b0, 1'b0, '0},
        '{CMD_ADD_REF, 4'd5, 4'd7, 1'b0, 1'b0, '0},
        '{CMD_QUERY_PAIR, 4'd0, 4'd0, 1'b1, 1'b1, '{20'd1, 1'b0, ST_OK}},
        '{CMD_QUERY_PAIR, 4'd15, 4'd0, 1'b0, 1'b0, '0},
        '{CMD_QUERY_TOTAL, 4'd15, 4'd0, 1'b0, 1'b0, '0},
        '{CMD_MARK_UNUSED, 4'd3, 4'd3, 1'b0, 1'b0, '0},
        '{CMD_QUERY_USED, 4'd15, 4'd0, 1'b0, 1'b0, '0},
        '{CMD_QUERY_USED, 4'd5, 4'd0, 1'b0, 1'b0, '0},
        '{CMD_QUERY_TOTAL, 4'd5, 4'd0, 1'b0, 1'b0, '0},
        '{3'd6, 4'd15, 4'd15, 1'b1, 1'b1, '{20'd0, 1'b0, ST_OK}},
        '{3'd7, 4'd0, 4'd0, 1'b0, 1'b1, '{20'd0, 1'b0, ST_OK}},
        '{CMD_DECLARE, 4'd9, 4'd0, 1'b0, 1'b0, '0},
        '{CMD_MARK_UNUSED, 4'd15, 4'd15, 1'b1, 1'b0, '0},
        '{CMD_QUERY_USED, 4'd9, 4'd0, 1'b0, 1'b0, '0}
    };

    // random word: mostly well-formed graph building with occasional random marks
    task automatic send_random();
        int pick;
        logic [2:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 8) cmd = CMD_DECLARE;
        else if (pick < 50) cmd = CMD_ADD_REF;
        else if (pick < 62) cmd = CMD_QUERY_PAIR;
        else if (pick < 74) cmd = CMD_QUERY_TOTAL;
        else if (pick < 80) cmd = CMD_MARK_UNUSED;
        else if (pick < 97) cmd = CMD_QUERY_USED;
        else cmd = 3'($urandom_range(6, 7));
        send_word(cmd, 4'($urandom), 4'($urandom), 1'($urandom_range(0, 3) == 0), 0, '0);
    endtask

    // sender
    initial begin
        int burst;
        in_ch.valid = 1'b0;
        in_ch.cmd = '0;
        in_ch.node_id = '0;
        in_ch.parent_id = '0;
        in_ch.parent_is_root = 1'b0;
        i_rst_n = 1'b0;
        fail_cnt = 0;
        result_cnt = 0;
        word_cnt = 0;
        long_stall = 0;
        stim_done = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_word(dir_rows[k].cmd, dir_rows[k].node, dir_rows[k].parent,
                      dir_rows[k].root, dir_rows[k].chk, dir_rows[k].res);
        drain();

        // long receiver hold-off while input keeps coming
        long_stall = 400;
        for (int k = 0; k < 20; k++) send_random();
        drain();

        while (word_cnt < RANDOM_WORDS) begin
            burst = $urandom_range(1, 30);
            repeat (burst) send_random();
            if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 40));
            else if ($urandom_range(0, 20) == 0) drain();
        end
        drain();
        stim_done = 1;
    end

    // receiver and checker
    initial begin
        t_result got;
        t_result exp_res;
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (long_stall) @(posedge i_clk);
                long_stall = 0;
            end
            stall = $urandom_range(0, 9);
            out_ch.ready <= (stall > 2) || ((cycle_cnt / 500) % 3 == 0);
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.count, out_ch.used, out_ch.status};
                result_cnt++;
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result word %h", $time, got);
                    fail_cnt++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got.count != exp_res.count) begin
                        $display("%0t count expected %0d actual %0d", $time,
                                 exp_res.count, got.count);
                        fail_cnt++;
                    end
                    if (got.used != exp_res.used) begin
                        $display("%0t used expected %0d actual %0d", $time,
                                 exp_res.used, got.used);
                        fail_cnt++;
                    end
                    if (got.status != exp_res.status) begin
                        $display("%0t status expected %0d actual %0d", $time,
                                 exp_res.status, got.status);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        repeat (200) @(posedge i_clk);
        if (expected_results.size() != 0) fail_cnt++;
        $display("sent %0d command words (table, long hold-off, random bursts), got %0d results",
                 word_cnt, result_cnt);
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
